// ===== rtl/tlvv_pkg.sv =====
// Shared types and constants for the TLV record validator.
package tlvv_pkg;

  localparam logic [2:0]  HDR_LAST      = 3'd7;
  localparam logic [31:0] FLD_HDR_BYTES = 32'd8;
  localparam logic [15:0] SCHEMA_V1     = 16'd1;

  localparam logic [3:0] ERR_OK      = 4'd0;
  localparam logic [3:0] ERR_SHORT   = 4'd1;
  localparam logic [3:0] ERR_SCHEMA  = 4'd2;
  localparam logic [3:0] ERR_TYPE    = 4'd3;
  localparam logic [3:0] ERR_LENGTH  = 4'd4;
  localparam logic [3:0] ERR_TRUNC   = 4'd5;
  localparam logic [3:0] ERR_TAG     = 4'd6;
  localparam logic [3:0] ERR_FLAGS   = 4'd7;
  localparam logic [3:0] ERR_OVERRUN = 4'd8;

  localparam logic KIND_DESC    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    PH_RECORD = 2'd0,
    PH_FIELD  = 2'd1,
    PH_VALUE  = 2'd2
  } tlvv_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } tlvv_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] tag_value;
    logic [31:0] value_offset;
    logic [31:0] value_length;
    logic [15:0] schema_seen;
    logic [15:0] type_seen;
    logic [3:0]  error_code;
    logic        last_of_run;
  } tlvv_out_t;

  // One queue entry: the results caused by one input beat.
  typedef struct packed {
    logic        has_desc;
    logic        has_verdict;
    logic [15:0] tag;
    logic [31:0] offset;
    logic [31:0] field_len;
    logic [31:0] body_len;
    logic [15:0] schema;
    logic [15:0] rec_type;
    logic [3:0]  err;
  } tlvv_evt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tlvv_qstat_t;

endpackage

// ===== rtl/tlv_record_validator_top.sv =====
// Top level of the TLV record validator: parse front end, entry queue, result back end.
//
//   channel  ports                        beat
//   input    push / full / in_data        one record byte with last-byte mark
//   result   empty / pop / out_data       one field descriptor or record verdict
//   config   cfg_valid / cfg_ready / cfg_data   expected schema value
//
// One byte per cycle is taken while full is low and parsed in the cycle it is taken.
// The back end delivers one result per cycle while results are popped; a byte that
// ends a field header on the last byte yields two results from a single queue entry.
// full rises only when all QUEUE_DEPTH entries wait on the result side.
// Reset is synchronous; it clears the parser and sets the expected schema to 1.
module tlv_record_validator_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  tlvv_pkg::tlvv_in_t   in_data,
  output logic                 empty,
  input  logic                 pop,
  output tlvv_pkg::tlvv_out_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);
  import tlvv_pkg::*;

  tlvv_qstat_t q_stat;
  tlvv_evt_t   q_wdata;
  tlvv_evt_t   q_rdata;
  logic        q_push;
  logic        q_pop;

  tlvv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  tlvv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_stat  (q_stat)
  );

  tlvv_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

// ===== rtl/tlvv_front.sv =====
// Front end: accepts record bytes, runs the parse checks, builds result entries.
module tlvv_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  tlvv_pkg::tlvv_in_t     in_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [15:0]            cfg_data,
  input  tlvv_pkg::tlvv_qstat_t  q_stat,
  output logic                   q_push,
  output tlvv_pkg::tlvv_evt_t    q_wdata
);
  import tlvv_pkg::*;

  logic [15:0] exp_r;
  tlvv_phase_t phase_r, phase_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] off_r, off_nxt;
  logic [31:0] blen_r, blen_nxt;
  logic [15:0] schema_r, schema_nxt;
  logic [15:0] type_r, type_nxt;
  logic [15:0] prev_r, prev_nxt;
  logic [15:0] tag_r, tag_nxt;
  logic [15:0] flags_r, flags_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [3:0]  err_r, err_nxt;

  logic        accept;
  logic        desc_hit;
  logic [3:0]  err_fin;
  logic [31:0] off_inc;
  logic [31:0] room;
  logic [31:0] room_after;
  logic [31:0] len_fin;
  logic [7:0]  b;

  assign cfg_ready  = 1'b1;
  assign full       = q_stat.full;
  assign accept     = push & ~q_stat.full;
  assign b          = in_data.data_byte;
  assign off_inc    = off_r + 32'd1;
  assign room       = blen_r - off_r;
  assign room_after = blen_r - off_inc;
  assign len_fin    = {acc_r[23:0], b};

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    off_nxt    = off_r;
    blen_nxt   = blen_r;
    schema_nxt = schema_r;
    type_nxt   = type_r;
    prev_nxt   = prev_r;
    tag_nxt    = tag_r;
    flags_nxt  = flags_r;
    acc_nxt    = acc_r;
    rem_nxt    = rem_r;
    err_nxt    = err_r;
    desc_hit   = 1'b0;
    err_fin    = ERR_OK;
    q_push     = 1'b0;
    q_wdata    = '0;
    if (accept && err_r == ERR_OK) begin
      unique case (phase_r)
        PH_RECORD: begin
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r < 3'd2) begin
            schema_nxt = {schema_r[7:0], b};
          end else if (cnt_r < 3'd4) begin
            type_nxt = {type_r[7:0], b};
          end else begin
            blen_nxt = {blen_r[23:0], b};
          end
          if (cnt_r == HDR_LAST) begin
            cnt_nxt   = '0;
            phase_nxt = PH_FIELD;
            if (schema_r != exp_r) begin
              err_nxt = ERR_SCHEMA;
            end else if (type_r == '0) begin
              err_nxt = ERR_TYPE;
            end
          end
        end
        PH_FIELD, PH_VALUE: begin
          if (off_r >= blen_r) begin
            err_nxt = ERR_LENGTH;
          end else if (phase_r == PH_VALUE) begin
            off_nxt = off_inc;
            rem_nxt = rem_r - 32'd1;
            if (rem_r == 32'd1) begin
              phase_nxt = PH_FIELD;
            end
          end else if (cnt_r == '0 && room < FLD_HDR_BYTES) begin
            err_nxt = ERR_TRUNC;
          end else begin
            off_nxt = off_inc;
            cnt_nxt = cnt_r + 3'd1;
            if (cnt_r < 3'd2) begin
              tag_nxt = {tag_r[7:0], b};
            end else if (cnt_r < 3'd4) begin
              flags_nxt = {flags_r[7:0], b};
            end else begin
              acc_nxt = len_fin;
            end
            if (cnt_r == HDR_LAST) begin
              cnt_nxt = '0;
              if (tag_r == '0 || tag_r <= prev_r) begin
                err_nxt = ERR_TAG;
              end else if (flags_r != '0) begin
                err_nxt = ERR_FLAGS;
              end else if (len_fin > room_after) begin
                err_nxt = ERR_OVERRUN;
              end else begin
                desc_hit  = 1'b1;
                prev_nxt  = tag_r;
                rem_nxt   = len_fin;
                phase_nxt = (len_fin != '0) ? PH_VALUE : PH_FIELD;
              end
              tag_nxt   = '0;
              flags_nxt = '0;
              acc_nxt   = '0;
            end
          end
        end
        default: ;
      endcase
    end

    err_fin = err_nxt;
    if (err_nxt == ERR_OK) begin
      if (phase_nxt == PH_RECORD) begin
        err_fin = ERR_SHORT;
      end else if (off_nxt != blen_nxt) begin
        err_fin = ERR_LENGTH;
      end
    end

    q_wdata.has_desc    = desc_hit;
    q_wdata.has_verdict = in_data.last_byte;
    q_wdata.tag         = tag_r;
    q_wdata.offset      = off_inc;
    q_wdata.field_len   = len_fin;
    q_wdata.body_len    = blen_nxt;
    q_wdata.schema      = schema_nxt;
    q_wdata.rec_type    = type_nxt;
    q_wdata.err         = err_fin;
    q_push              = accept & (desc_hit | in_data.last_byte);

    if (accept && in_data.last_byte) begin
      phase_nxt  = PH_RECORD;
      cnt_nxt    = '0;
      off_nxt    = '0;
      blen_nxt   = '0;
      schema_nxt = '0;
      type_nxt   = '0;
      prev_nxt   = '0;
      tag_nxt    = '0;
      flags_nxt  = '0;
      acc_nxt    = '0;
      rem_nxt    = '0;
      err_nxt    = ERR_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r    <= SCHEMA_V1;
      phase_r  <= PH_RECORD;
      cnt_r    <= '0;
      off_r    <= '0;
      blen_r   <= '0;
      schema_r <= '0;
      type_r   <= '0;
      prev_r   <= '0;
      tag_r    <= '0;
      flags_r  <= '0;
      acc_r    <= '0;
      rem_r    <= '0;
      err_r    <= ERR_OK;
    end else begin
      if (cfg_valid && cfg_ready) begin
        exp_r <= cfg_data;
      end
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      off_r    <= off_nxt;
      blen_r   <= blen_nxt;
      schema_r <= schema_nxt;
      type_r   <= type_nxt;
      prev_r   <= prev_nxt;
      tag_r    <= tag_nxt;
      flags_r  <= flags_nxt;
      acc_r    <= acc_nxt;
      rem_r    <= rem_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

// ===== rtl/tlvv_queue.sv =====
// Short entry queue between the parse front end and the result back end.
module tlvv_queue #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_push,
  input  tlvv_pkg::tlvv_evt_t    q_wdata,
  input  logic                   q_pop,
  output tlvv_pkg::tlvv_evt_t    q_rdata,
  output tlvv_pkg::tlvv_qstat_t  q_stat
);
  import tlvv_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  tlvv_evt_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign q_stat.full  = (cnt_r == CNT_FULL);
  assign q_stat.empty = (cnt_r == '0);
  assign do_wr        = q_push & ~q_stat.full;
  assign do_rd        = q_pop & ~q_stat.empty;
  assign q_rdata      = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wr_nxt = (wr_r == PTR_LAST) ? '0 : wr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_nxt = (rd_r == PTR_LAST) ? '0 : rd_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_r] <= q_wdata;
    end
  end

endmodule

// ===== rtl/tlvv_back.sv =====
// Back end: splits queue entries into result beats and holds the output register.
module tlvv_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tlvv_pkg::tlvv_qstat_t  q_stat,
  input  tlvv_pkg::tlvv_evt_t    q_rdata,
  output logic                   q_pop,
  output logic                   empty,
  input  logic                   pop,
  output tlvv_pkg::tlvv_out_t    out_data
);
  import tlvv_pkg::*;

  logic      out_vld_r, out_vld_nxt;
  logic      sel_r, sel_nxt;
  tlvv_out_t out_r, out_nxt;
  logic      load;
  logic      take_desc;

  assign empty     = ~out_vld_r;
  assign out_data  = out_r;
  assign load      = ~q_stat.empty & (~out_vld_r | pop);
  assign take_desc = q_rdata.has_desc & ~sel_r;

  always_comb begin
    out_vld_nxt = out_vld_r;
    sel_nxt     = sel_r;
    out_nxt     = out_r;
    q_pop       = 1'b0;
    if (pop && out_vld_r) begin
      out_vld_nxt = 1'b0;
    end
    if (load) begin
      out_vld_nxt          = 1'b1;
      out_nxt.schema_seen  = q_rdata.schema;
      out_nxt.type_seen    = q_rdata.rec_type;
      if (take_desc) begin
        out_nxt.result_kind  = KIND_DESC;
        out_nxt.tag_value    = q_rdata.tag;
        out_nxt.value_offset = q_rdata.offset;
        out_nxt.value_length = q_rdata.field_len;
        out_nxt.error_code   = ERR_OK;
        out_nxt.last_of_run  = ~q_rdata.has_verdict;
      end else begin
        out_nxt.result_kind  = KIND_VERDICT;
        out_nxt.tag_value    = '0;
        out_nxt.value_offset = '0;
        out_nxt.value_length = q_rdata.body_len;
        out_nxt.error_code   = q_rdata.err;
        out_nxt.last_of_run  = 1'b1;
      end
      if (take_desc && q_rdata.has_verdict) begin
        sel_nxt = 1'b1;
      end else begin
        sel_nxt = 1'b0;
        q_pop   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sel_r     <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      sel_r     <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

// ===== bench/tlvv_stream_checker.sv =====
// Result checker for the TLV record validator: tracks the parse, predicts each result beat and compares.
module tlvv_stream_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic                full,
  input  tlvv_pkg::tlvv_in_t  in_data,
  input  logic                empty,
  input  logic                pop,
  input  tlvv_pkg::tlvv_out_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  output int                  fail_count,
  output int                  pending,
  output int                  desc_count,
  output int                  verdict_count,
  output logic [15:0]         err_codes_seen
);
  import tlvv_pkg::*;

  localparam logic [32:0] REC_HDR_BYTES = 33'd8;
  localparam int          REPORT_LIMIT  = 10;

  logic [15:0] schema_cfg;
  tlvv_phase_t phase;
  logic [2:0]  hdr_cnt;
  logic [32:0] rec_pos;
  logic [31:0] body_len;
  logic [15:0] schema_rd;
  logic [15:0] type_rd;
  logic [15:0] prev_tag;
  logic [15:0] cur_tag;
  logic [15:0] cur_flags;
  logic [31:0] len_acc;
  logic [31:0] val_rem;
  logic [3:0]  first_err;

  tlvv_out_t   due_results[$];
  int          mismatches = 0;
  int          ndesc = 0;
  int          nverd = 0;
  int          checked = 0;
  logic [15:0] codes = '0;

  task automatic clear_record();
    phase     = PH_RECORD;
    hdr_cnt   = '0;
    rec_pos   = '0;
    body_len  = '0;
    schema_rd = '0;
    type_rd   = '0;
    prev_tag  = '0;
    cur_tag   = '0;
    cur_flags = '0;
    len_acc   = '0;
    val_rem   = '0;
    first_err = ERR_OK;
  endtask

  function automatic void queue_result(input logic kind, input logic [15:0] tag,
                                       input logic [31:0] off, input logic [31:0] len,
                                       input logic [3:0] err);
    tlvv_out_t r;
    r.result_kind  = kind;
    r.tag_value    = tag;
    r.value_offset = off;
    r.value_length = len;
    r.schema_seen  = schema_rd;
    r.type_seen    = type_rd;
    r.error_code   = err;
    r.last_of_run  = 1'b0;
    due_results.push_back(r);
  endfunction

  task automatic parse_record_byte(input tlvv_in_t beat);
    logic [7:0]  b;
    logic [32:0] off;
    tlvv_out_t   r;
    int          produced;
    b = beat.data_byte;
    produced = 0;
    if (first_err == ERR_OK) begin
      if (phase == PH_RECORD) begin
        if (hdr_cnt < 3'd2) schema_rd = {schema_rd[7:0], b};
        else if (hdr_cnt < 3'd4) type_rd = {type_rd[7:0], b};
        else body_len = {body_len[23:0], b};
        rec_pos = rec_pos + 33'd1;
        if (hdr_cnt == HDR_LAST) begin
          hdr_cnt = '0;
          phase = PH_FIELD;
          if (schema_rd != schema_cfg) first_err = ERR_SCHEMA;
          else if (type_rd == 16'h0) first_err = ERR_TYPE;
        end else begin
          hdr_cnt = hdr_cnt + 3'd1;
        end
      end else begin
        off = rec_pos - REC_HDR_BYTES;
        if (off >= {1'b0, body_len}) begin
          first_err = ERR_LENGTH;
        end else if (phase == PH_VALUE) begin
          rec_pos = rec_pos + 33'd1;
          val_rem = val_rem - 32'd1;
          if (val_rem == 32'd0) phase = PH_FIELD;
        end else if (phase == PH_FIELD) begin
          if (hdr_cnt == 3'd0 && ({1'b0, body_len} - off) < {1'b0, FLD_HDR_BYTES}) begin
            first_err = ERR_TRUNC;
          end else begin
            if (hdr_cnt < 3'd2) cur_tag = {cur_tag[7:0], b};
            else if (hdr_cnt < 3'd4) cur_flags = {cur_flags[7:0], b};
            else len_acc = {len_acc[23:0], b};
            rec_pos = rec_pos + 33'd1;
            if (hdr_cnt != HDR_LAST) begin
              hdr_cnt = hdr_cnt + 3'd1;
            end else begin
              hdr_cnt = '0;
              off = rec_pos - REC_HDR_BYTES;
              if (cur_tag == 16'h0 || cur_tag <= prev_tag) begin
                first_err = ERR_TAG;
              end else if (cur_flags != 16'h0) begin
                first_err = ERR_FLAGS;
              end else if ({1'b0, len_acc} > ({1'b0, body_len} - off)) begin
                first_err = ERR_OVERRUN;
              end else begin
                queue_result(KIND_DESC, cur_tag, off[31:0], len_acc, ERR_OK);
                produced++;
                prev_tag = cur_tag;
                val_rem = len_acc;
                phase = (len_acc != 32'd0) ? PH_VALUE : PH_FIELD;
              end
              cur_tag   = '0;
              cur_flags = '0;
              len_acc   = '0;
            end
          end
        end
      end
    end
    if (beat.last_byte) begin
      if (first_err == ERR_OK) begin
        if (phase == PH_RECORD) first_err = ERR_SHORT;
        else if ((rec_pos - REC_HDR_BYTES) != {1'b0, body_len}) first_err = ERR_LENGTH;
      end
      queue_result(KIND_VERDICT, 16'h0, 32'h0, body_len, first_err);
      produced++;
      clear_record();
    end
    if (produced > 0) begin
      r = due_results.pop_back();
      r.last_of_run = 1'b1;
      due_results.push_back(r);
    end
  endtask

  task automatic check_result(input tlvv_out_t got);
    tlvv_out_t want;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("result beat %0d not expected: kind=%0d tag=%h err=%0d", checked,
                 got.result_kind, got.tag_value, got.error_code);
    end else begin
      want = due_results.pop_front();
      if (got.result_kind !== want.result_kind || got.tag_value !== want.tag_value ||
          got.value_offset !== want.value_offset || got.value_length !== want.value_length ||
          got.schema_seen !== want.schema_seen || got.type_seen !== want.type_seen ||
          got.error_code !== want.error_code || got.last_of_run !== want.last_of_run) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result beat %0d mismatch", checked);
          $display("  want kind=%0d tag=%h off=%0d len=%0d schema=%h type=%h err=%0d last=%0d",
                   want.result_kind, want.tag_value, want.value_offset, want.value_length,
                   want.schema_seen, want.type_seen, want.error_code, want.last_of_run);
          $display("  got  kind=%0d tag=%h off=%0d len=%0d schema=%h type=%h err=%0d last=%0d",
                   got.result_kind, got.tag_value, got.value_offset, got.value_length,
                   got.schema_seen, got.type_seen, got.error_code, got.last_of_run);
        end
      end
      if (want.result_kind == KIND_VERDICT) begin
        nverd++;
        codes[want.error_code] = 1'b1;
      end else begin
        ndesc++;
      end
    end
    checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_record();
      schema_cfg = SCHEMA_V1;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) schema_cfg = cfg_data;
      if (pop && !empty) check_result(out_data);
      if (push && !full) parse_record_byte(in_data);
    end
    fail_count     <= mismatches;
    pending        <= due_results.size();
    desc_count     <= ndesc;
    verdict_count  <= nverd;
    err_codes_seen <= codes;
  end

endmodule

// ===== bench/tlv_record_validator_top_tb.sv =====
// Testbench top for the TLV record validator: clock, reset, record stimulus and verdict.
module tlv_record_validator_top_tb;
  import tlvv_pkg::*;

  localparam int ITEMS         = 1700;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {
    SHAPE_GOOD,
    SHAPE_BAD_SCHEMA,
    SHAPE_ZERO_TYPE,
    SHAPE_BODY_CUT,
    SHAPE_BODY_EXTRA,
    SHAPE_TRUNC,
    SHAPE_BAD_TAG,
    SHAPE_FLAGS,
    SHAPE_OVERRUN,
    SHAPE_SHORT_HDR,
    SHAPE_NOISE
  } rec_shape_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  tlvv_in_t    in_data = '0;
  logic        empty;
  logic        pop = 1'b0;
  tlvv_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int          fail_count;
  int          pending;
  int          desc_count;
  int          verdict_count;
  logic [15:0] err_codes_seen;

  int          cycles = 0;
  int          sent_bytes = 0;
  int          sent_records = 0;
  int          schema_writes = 0;
  int          send_quiet = 0;
  int          pop_quiet = 0;
  int          pop_hold = 0;
  logic [15:0] cur_schema = SCHEMA_V1;
  logic [7:0]  rec_buf[$];

  tlv_record_validator_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  tlvv_stream_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_data        (in_data),
    .empty          (empty),
    .pop            (pop),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .desc_count     (desc_count),
    .verdict_count  (verdict_count),
    .err_codes_seen (err_codes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("FAIL");
      $finish;
    end
  end

  // result side: short and long stalls, with stall-free stretches
  always @(negedge clk) begin
    int roll;
    roll = $urandom_range(0, 99);
    if (pop_hold > 0) begin
      pop_hold--;
      pop <= 1'b0;
    end else if (pop_quiet > 0) begin
      pop_quiet--;
      pop <= 1'b1;
    end else begin
      if (roll < 3) pop_quiet = $urandom_range(20, 80);
      else if (roll < 25) pop_hold = $urandom_range(1, 3);
      else if (roll < 28) pop_hold = $urandom_range(8, 40);
      pop <= (pop_hold == 0);
    end
  end

  function automatic void put16(input logic [15:0] v);
    rec_buf.push_back(v[15:8]);
    rec_buf.push_back(v[7:0]);
  endfunction

  function automatic void put32(input logic [31:0] v);
    put16(v[31:16]);
    put16(v[15:0]);
  endfunction

  task automatic send_record();
    int       gap;
    int       roll;
    tlvv_in_t beat;
    for (int i = 0; i < rec_buf.size(); i++) begin
      gap = 0;
      roll = $urandom_range(0, 99);
      if (send_quiet > 0) send_quiet--;
      else if (roll < 3) send_quiet = $urandom_range(20, 80);
      else if (roll < 28) gap = $urandom_range(1, 3);
      else if (roll < 31) gap = $urandom_range(8, 40);
      if (gap > 0) begin
        @(negedge clk);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      beat.data_byte = rec_buf[i];
      beat.last_byte = (i == rec_buf.size() - 1);
      push    <= 1'b1;
      in_data <= beat;
      do @(posedge clk); while (full);
      sent_bytes++;
    end
    sent_records++;
  endtask

  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_schema(input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_schema = v;
    schema_writes++;
  endtask

  task automatic random_records(input int target);
    rec_shape_t  shape;
    int          roll;
    int          nf;
    int          bad_at;
    int          vbytes;
    bit          field_fault;
    bit          tag_done;
    logic [16:0] next_tag;
    logic [15:0] ftag;
    logic [15:0] fflags;
    logic [15:0] prev_tag;
    logic [15:0] rschema;
    logic [15:0] rtype;
    logic [31:0] vlen;
    logic [31:0] body_size;
    while (sent_bytes < target) begin
      roll = $urandom_range(0, 99);
      shape = (roll < 52) ? SHAPE_GOOD
                          : rec_shape_t'(int'(SHAPE_BAD_SCHEMA) + (roll - 52) / 5);
      rec_buf.delete();
      if (shape == SHAPE_SHORT_HDR || shape == SHAPE_NOISE) begin
        repeat ((shape == SHAPE_SHORT_HDR) ? $urandom_range(1, 7) : $urandom_range(1, 40))
          rec_buf.push_back(8'($urandom));
      end else begin
        rschema = cur_schema;
        if (shape == SHAPE_BAD_SCHEMA) rschema = cur_schema ^ 16'($urandom_range(1, 16'hFFFF));
        if (shape == SHAPE_ZERO_TYPE) rtype = 16'h0;
        else if ($urandom_range(0, 7) == 0) rtype = 16'hFFFF;
        else rtype = 16'($urandom_range(1, 16'hFFFF));
        put16(rschema);
        put16(rtype);
        put32(32'h0);
        field_fault = (shape == SHAPE_BAD_TAG || shape == SHAPE_FLAGS ||
                       shape == SHAPE_OVERRUN);
        nf = $urandom_range(0, 4);
        if (field_fault && nf == 0) nf = 1;
        bad_at = (shape == SHAPE_OVERRUN) ? nf - 1 : $urandom_range(0, (nf > 0) ? nf - 1 : 0);
        next_tag = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(16'hFF00, 16'hFFFF))
                                                : 17'($urandom_range(1, 300));
        prev_tag = 16'h0;
        tag_done = 1'b0;
        for (int i = 0; i < nf && !tag_done; i++) begin
          ftag = next_tag[15:0];
          fflags = 16'h0;
          vbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
          vlen = vbytes;
          if (i == bad_at) begin
            case (shape)
              SHAPE_BAD_TAG: begin
                if (i == 0 || $urandom_range(0, 2) == 0) ftag = 16'h0;
                else ftag = prev_tag - 16'($urandom_range(0, prev_tag - 1));
              end
              SHAPE_FLAGS: begin
                fflags = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                     : 16'($urandom_range(1, 16'hFFFF));
              end
              SHAPE_OVERRUN: begin
                vlen = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                   : vbytes + $urandom_range(1, 300);
              end
              default: ;
            endcase
          end
          put16(ftag);
          put16(fflags);
          put32(vlen);
          repeat (vbytes) rec_buf.push_back(8'($urandom));
          prev_tag = ftag;
          if (next_tag == 17'h0FFFF) tag_done = 1'b1;
          next_tag = next_tag + 17'($urandom_range(1, 12000));
          if (next_tag > 17'h0FFFF) next_tag = 17'h0FFFF;
        end
        if (shape == SHAPE_TRUNC)
          repeat ($urandom_range(1, 7)) rec_buf.push_back(8'($urandom));
        body_size = rec_buf.size() - 8;
        if (shape == SHAPE_BODY_CUT)
          body_size = ($urandom_range(0, 3) == 0) ? $urandom : body_size + $urandom_range(1, 20);
        rec_buf[4] = body_size[31:24];
        rec_buf[5] = body_size[23:16];
        rec_buf[6] = body_size[15:8];
        rec_buf[7] = body_size[7:0];
        if (shape == SHAPE_BODY_EXTRA)
          repeat ($urandom_range(1, 4)) rec_buf.push_back(8'($urandom));
      end
      send_record();
    end
  endtask

  initial begin
    logic [15:0] phase_schema [4];
    phase_schema[0] = 16'h0000;
    phase_schema[1] = 16'hFFFF;
    phase_schema[2] = 16'($urandom_range(2, 16'hFFFE));
    phase_schema[3] = SCHEMA_V1;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // lone byte, header-only record, field header closing on the last byte
    rec_buf.delete();
    rec_buf.push_back(8'hFF);
    send_record();
    rec_buf.delete();
    put16(SCHEMA_V1);
    put16(16'hFFFF);
    put32(32'h0);
    send_record();
    rec_buf.delete();
    put16(SCHEMA_V1);
    put16(16'h0001);
    put32(32'd8);
    put16(16'hFFFF);
    put16(16'h0000);
    put32(32'h0);
    send_record();

    for (int p = 0; p < 4; p++) begin
      settle();
      write_schema(phase_schema[p]);
      random_records(sent_bytes + ITEMS / 4);
    end
    settle();
    @(negedge clk);

    $display("sent %0d bytes in %0d records under %0d schema settings incl. 0 and ffff",
             sent_bytes, sent_records, schema_writes + 1);
    $display("checked %0d field descriptors and %0d verdicts, verdict codes seen %b",
             desc_count, verdict_count, err_codes_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tlvv_pkg.sv
rtl/tlvv_front.sv
rtl/tlvv_queue.sv
rtl/tlvv_back.sv
rtl/tlv_record_validator_top.sv
bench/tlvv_stream_checker.sv
bench/tlv_record_validator_top_tb.sv
